[design/tf256_pkg.sv]
// types, constants and round functions for the threefish-256 pipeline
// no dependencies
package tf256_pkg;

  typedef logic [63:0] word_t;
  typedef word_t [3:0] block_t;
  typedef word_t [4:0] key_t;
  typedef word_t [2:0] tweak_t;

  typedef struct packed {
    logic   mode;
    block_t x;
  } stage_t;

  localparam int NumRounds  = 72;
  localparam int NumSubkeys = 19;
  localparam int NumStages  = NumRounds + 2;
  localparam word_t KsParity = 64'h1BD1_1BDA_A9FC_1A22;

  // register indexes on the config port
  localparam logic [2:0] RegKey0   = 3'd0;
  localparam logic [2:0] RegKey1   = 3'd1;
  localparam logic [2:0] RegKey2   = 3'd2;
  localparam logic [2:0] RegKey3   = 3'd3;
  localparam logic [2:0] RegTweak0 = 3'd4;
  localparam logic [2:0] RegTweak1 = 3'd5;

  localparam logic ModeEnc = 1'b0;

  localparam int Rot0 [8] = '{14, 52, 23, 5, 25, 46, 58, 32};
  localparam int Rot1 [8] = '{16, 57, 40, 37, 33, 12, 22, 32};

  function automatic word_t rotl(word_t x, int r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic word_t rotr(word_t x, int r);
    return (x >> r) | (x << (64 - r));
  endfunction

  // subkey s, all four words
  function automatic block_t subkey(key_t k, tweak_t t, int s);
    block_t v;
    for (int i = 0; i < 4; i++) v[i] = k[(s + i) % 5];
    v[1] = v[1] + t[s % 3];
    v[2] = v[2] + t[(s + 1) % 3];
    v[3] = v[3] + word_t'(s);
    return v;
  endfunction

  function automatic block_t enc_round(block_t xi, int d, key_t k, tweak_t t);
    block_t x;
    block_t y;
    block_t sk;
    x  = xi;
    sk = subkey(k, t, d / 4);
    if (d % 4 == 0) begin
      for (int i = 0; i < 4; i++) x[i] = x[i] + sk[i];
    end
    y[0] = x[0] + x[1];
    y[1] = rotl(x[1], Rot0[d % 8]) ^ y[0];
    y[2] = x[2] + x[3];
    y[3] = rotl(x[3], Rot1[d % 8]) ^ y[2];
    return {y[1], y[2], y[3], y[0]};
  endfunction

  function automatic block_t dec_round(block_t x, int d, key_t k, tweak_t t);
    block_t y;
    block_t sk;
    sk   = subkey(k, t, d / 4);
    y[1] = rotr(x[3] ^ x[0], Rot0[d % 8]);
    y[0] = x[0] - y[1];
    y[3] = rotr(x[1] ^ x[2], Rot1[d % 8]);
    y[2] = x[2] - y[3];
    if (d % 4 == 0) begin
      for (int i = 0; i < 4; i++) y[i] = y[i] - sk[i];
    end
    return y;
  endfunction

endpackage

[design/tf256_if.sv]
// stream channels for the threefish-256 block: input items and result items
// depends on tf256_pkg
interface tf256_in_if import tf256_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  mode;
  word_t in_word0;
  word_t in_word1;
  word_t in_word2;
  word_t in_word3;
  modport source (output valid, mode, in_word0, in_word1, in_word2, in_word3, input ready);
  modport sink (input valid, mode, in_word0, in_word1, in_word2, in_word3, output ready);
endinterface

interface tf256_out_if import tf256_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t out_word0;
  word_t out_word1;
  word_t out_word2;
  word_t out_word3;
  modport source (output valid, out_word0, out_word1, out_word2, out_word3, input ready);
  modport sink (input valid, out_word0, out_word1, out_word2, out_word3, output ready);
endinterface

[design/threefish256_block_cipher.sv]
// threefish-256 tweakable block cipher, fully unrolled pipeline
// depends on tf256_pkg and the stream interfaces in tf256_if
//
// channel   dir  handshake      payload
// in_i      in   valid/ready    mode, in_word0..in_word3
// out_o     out  valid/ready    out_word0..out_word3
// apb       in   psel/penable   key_word0..3, tweak_word0..1 at 8*i
//
// one item enters per cycle while the pipe advances; the pipe has a pre stage, 72 round
// stages and a post stage, with one mix round per round stage
// the whole pipe advances together; while a result waits untaken the pipe
// holds, and input is accepted again as soon as it moves
// reset clears the valid bits and the key and tweak registers
module threefish256_block_cipher
  import tf256_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  tf256_in_if.sink    in_i,
  tf256_out_if.source out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  // config registers
  word_t key_q [4];
  word_t tweak_q [2];
  key_t   kx;
  tweak_t tx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
      tweak_q[0] <= '0;
      tweak_q[1] <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[5:3])
        RegKey0:   key_q[0]   <= pwdata;
        RegKey1:   key_q[1]   <= pwdata;
        RegKey2:   key_q[2]   <= pwdata;
        RegKey3:   key_q[3]   <= pwdata;
        RegTweak0: tweak_q[0] <= pwdata;
        RegTweak1: tweak_q[1] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      RegKey0:   prdata = key_q[0];
      RegKey1:   prdata = key_q[1];
      RegKey2:   prdata = key_q[2];
      RegKey3:   prdata = key_q[3];
      RegTweak0: prdata = tweak_q[0];
      RegTweak1: prdata = tweak_q[1];
      default:   prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // parity key word and third tweak word
  assign kx = {KsParity ^ key_q[0] ^ key_q[1] ^ key_q[2] ^ key_q[3],
               key_q[3], key_q[2], key_q[1], key_q[0]};
  assign tx = {tweak_q[0] ^ tweak_q[1], tweak_q[1], tweak_q[0]};

  // pipeline
  logic [NumStages-1:0] v_q;
  stage_t st_q [NumStages];
  stage_t st_d [NumStages];
  logic   adv;

  // whole pipe moves unless the last result is stalled
  assign adv        = !v_q[NumStages-1] || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NumStages-2:0], in_i.valid};
    end
  end

  // pre stage: decrypt strips the last subkey first
  always_comb begin
    block_t sk;
    sk            = subkey(kx, tx, NumSubkeys - 1);
    st_d[0].mode  = in_i.mode;
    st_d[0].x     = {in_i.in_word3, in_i.in_word2, in_i.in_word1, in_i.in_word0};
    if (in_i.mode != ModeEnc) begin
      for (int i = 0; i < 4; i++) st_d[0].x[i] = st_d[0].x[i] - sk[i];
    end
  end

  // round stages: encrypt runs round j, decrypt undoes round 71-j
  for (genvar j = 0; j < NumRounds; j++) begin : g_round
    always_comb begin
      st_d[j+1].mode = st_q[j].mode;
      if (st_q[j].mode == ModeEnc) begin
        st_d[j+1].x = enc_round(st_q[j].x, j, kx, tx);
      end else begin
        st_d[j+1].x = dec_round(st_q[j].x, NumRounds - 1 - j, kx, tx);
      end
    end
  end

  // post stage: encrypt adds the last subkey
  always_comb begin
    block_t sk;
    sk                      = subkey(kx, tx, NumSubkeys - 1);
    st_d[NumStages-1]       = st_q[NumStages-2];
    if (st_q[NumStages-2].mode == ModeEnc) begin
      for (int i = 0; i < 4; i++) begin
        st_d[NumStages-1].x[i] = st_q[NumStages-2].x[i] + sk[i];
      end
    end
  end

  for (genvar k = 0; k < NumStages; k++) begin : g_reg
    always_ff @(posedge clk_i) begin
      if (adv) st_q[k] <= st_d[k];
    end
  end

  assign out_o.valid     = v_q[NumStages-1];
  assign out_o.out_word0 = st_q[NumStages-1].x[0];
  assign out_o.out_word1 = st_q[NumStages-1].x[1];
  assign out_o.out_word2 = st_q[NumStages-1].x[2];
  assign out_o.out_word3 = st_q[NumStages-1].x[3];

endmodule
